// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker in deq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/deq_pkg.sv
package deq_pkg;

    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [2:0] FUNC_DUMP       = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic               last;
    } rsp_t;

endpackage

// File: hw/rtl/deq_ram.sv
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [31:0]  rd_data
);

    logic signed [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/double_ended_queue_core.sv
// Bounded double-ended queue of signed 32-bit values held in a DEPTH-entry ring memory
// with a front pointer and an entry count. One request is worked at a time. A push
// answers in the cycle after acceptance; a pop's value passes through the registered
// memory read port and then the result register in ST_POP. A dump of N entries first
// reads the front entry, then gives one result per cycle while the consumer does not
// stall; an empty dump, empty pop or full push answers in the cycle after acceptance.
// The next request is taken once the block is back idle and the result register is
// free or being drained. The ring memory's single read port sets pop and dump timing.
module double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  deq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output deq_pkg::rsp_t rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DUMP
    } state_t;

    state_t             state_reg, state_next;
    logic [PW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [PW-1:0]      dump_ptr_reg, dump_ptr_next;
    logic [CW-1:0]      dump_idx_reg, dump_idx_next;
    logic               rsp_valid_reg, rsp_valid_next;
    deq_pkg::rsp_t      rsp_reg, rsp_next;

    logic               wr_en;
    logic [PW-1:0]      wr_addr;
    logic               rd_en;
    logic [PW-1:0]      rd_addr;
    logic signed [31:0] rd_data;

    logic               out_free;
    logic               req_accept;
    logic               is_empty;
    logic               is_full;
    logic               dump_last;
    logic [PW-1:0]      front_dec;

    // (base + off) mod DEPTH, with base < DEPTH and off < DEPTH
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [PW:0] s;
        s = (PW + 1)'(base) + (PW + 1)'(off);
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[PW-1:0];
    endfunction

    deq_ram #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = !((state_reg == ST_IDLE) && out_free);
    assign req_accept = req_valid && !req_stall;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == DEPTH_C);
    assign dump_last  = (dump_idx_reg == (count_reg - ONE_C));
    assign front_dec  = (front_reg == '0) ? PW'(DEPTH - 1) : (front_reg - PW'(1));

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        dump_ptr_next  = dump_ptr_reg;
        dump_idx_next  = dump_idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = front_dec;
        rd_en          = 1'b0;
        rd_addr        = front_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    case (req.func)
                        deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            if (is_full)
                            begin
                                rsp_next = '{status: deq_pkg::STATUS_FULL,
                                             data_out: '0, last: 1'b1};
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (req.func == deq_pkg::FUNC_PUSH_FRONT)
                                begin
                                    wr_addr    = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    wr_addr = wrap_add(front_reg, count_reg);
                                end
                                count_next = count_reg + ONE_C;
                                rsp_next   = '{status: deq_pkg::STATUS_OK,
                                               data_out: '0, last: 1'b1};
                            end
                        end
                        deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = '{status: deq_pkg::STATUS_EMPTY,
                                             data_out: '0, last: 1'b1};
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                if (req.func == deq_pkg::FUNC_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = wrap_add(front_reg, ONE_C);
                                end
                                else
                                begin
                                    rd_addr = wrap_add(front_reg, count_reg - ONE_C);
                                end
                                count_next = count_reg - ONE_C;
                                state_next = ST_POP;
                            end
                        end
                        deq_pkg::FUNC_DUMP:
                        begin
                            if (is_empty)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = '{status: deq_pkg::STATUS_EMPTY,
                                             data_out: '0, last: 1'b1};
                            end
                            else
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = front_reg;
                                dump_ptr_next = wrap_add(front_reg, ONE_C);
                                dump_idx_next = '0;
                                state_next    = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            // unused codes: dropped, no response
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                // result register was free at acceptance, so it is empty here
                rsp_valid_next = 1'b1;
                rsp_next = '{status: deq_pkg::STATUS_OK, data_out: rd_data, last: 1'b1};
                state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                // rd_data holds the entry at dump_idx until the next read is issued
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next = '{status: deq_pkg::STATUS_OK, data_out: rd_data,
                                 last: dump_last};
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = dump_ptr_reg;
                        dump_ptr_next = wrap_add(dump_ptr_reg, ONE_C);
                        dump_idx_next = dump_idx_reg + ONE_C;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            dump_ptr_reg  <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            dump_ptr_reg  <= dump_ptr_next;
            dump_idx_reg  <= dump_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

// File: hw/rtl/deq_checker.sv
`include "assert_macros.svh"

module deq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input deq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input deq_pkg::rsp_t rsp
);

    logic push_accept;

    assign push_accept = req_valid && !req_stall &&
                         ((req.func == deq_pkg::FUNC_PUSH_FRONT) ||
                          (req.func == deq_pkg::FUNC_PUSH_BACK));

    `DEQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

    // empty and full answers are single responses
    `DEQ_ASSERT(a_err_last, clk, rst_n, !(rsp_valid && (rsp.status != deq_pkg::STATUS_OK)) || rsp.last, "error response not marked last")

    `DEQ_ASSERT(a_err_zero, clk, rst_n, !(rsp_valid && (rsp.status != deq_pkg::STATUS_OK)) || (rsp.data_out == 0), "error response carries data")

    // a push answers in the very next cycle
    `DEQ_ASSERT_NEXT(a_push_rsp, clk, rst_n, push_accept, rsp_valid && rsp.last && (rsp.data_out == 0), "push response missing")

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
